/* sv/crle_pkg.sv */
// crle_pkg: types and constants shared by the cut rle image decoder
// no dependencies
`timescale 1ns / 1ps
`default_nettype none

package crle_pkg;

  // header is six bytes: width lo/hi, height lo/hi, two ignored
  localparam int unsigned HeaderBytes = 6;
  localparam logic [2:0] HdrWidthLo  = 3'd0;
  localparam logic [2:0] HdrWidthHi  = 3'd1;
  localparam logic [2:0] HdrHeightLo = 3'd2;
  localparam logic [2:0] HdrHeightHi = 3'd3;
  localparam logic [2:0] HdrLast     = 3'(HeaderBytes - 1);

  localparam int unsigned CountBits = 7;
  localparam int unsigned RepeatBit = 7;

  typedef enum logic [2:0] {
    PH_HEADER  = 3'd0,
    PH_LENSKIP = 3'd1,
    PH_CONTROL = 3'd2,
    PH_REPEAT  = 3'd3,
    PH_LITERAL = 3'd4,
    PH_DONE    = 3'd5
  } phase_e;

  typedef enum logic [1:0] {
    KIND_SIZE = 2'd0,
    KIND_RUN  = 2'd1,
    KIND_EOL  = 2'd2
  } kind_e;

  typedef struct packed {
    logic                 valid;
    kind_e                kind;
    logic [15:0]          image_width;
    logic [15:0]          image_height;
    logic [7:0]           pixel_index;
    logic [CountBits-1:0] run_length;
    logic                 image_done;
  } result_t;

endpackage

`default_nettype wire

/* sv/crle_byte_if.sv */
// crle_byte_if: valid/ready channel carrying one file byte per word
// no dependencies
`timescale 1ns / 1ps
`default_nettype none

interface crle_byte_if;
  logic       valid;
  logic       ready;
  logic [7:0] data_byte;

  modport source (output valid, output data_byte, input ready);
  modport sink   (input valid, input data_byte, output ready);
endinterface

`default_nettype wire

/* sv/crle_result_if.sv */
// crle_result_if: valid/ready channel carrying one decoded result per word
// no dependencies
`timescale 1ns / 1ps
`default_nettype none

interface crle_result_if;
  logic        valid;
  logic        ready;
  logic [1:0]  kind;
  logic [15:0] image_width;
  logic [15:0] image_height;
  logic [7:0]  pixel_index;
  logic [6:0]  run_length;
  logic        image_done;

  modport source (output valid, output kind, output image_width, output image_height,
                  output pixel_index, output run_length, output image_done, input ready);
  modport sink   (input valid, input kind, input image_width, input image_height,
                  input pixel_index, input run_length, input image_done, output ready);
endinterface

`default_nettype wire

/* sv/crle_parser.sv */
// crle_parser: byte-level parse state machine, one byte per step
// depends on crle_pkg
`timescale 1ns / 1ps
`default_nettype none

module crle_parser (
  input  wire logic              clk_i,
  input  wire logic              rst_ni,
  input  wire logic              step_i,
  input  wire logic [7:0]        byte_i,
  output crle_pkg::result_t      res_o
);
  import crle_pkg::*;

  phase_e               phase_q, phase_d;
  logic [2:0]           hdr_pos_q, hdr_pos_d;
  logic [15:0]          width_q, width_d;
  logic [15:0]          lines_q, lines_d;
  logic [CountBits-1:0] pend_q, pend_d;
  logic                 skip_q, skip_d;

  logic [CountBits-1:0] count;
  logic [15:0]          lines_dec;
  logic [CountBits-1:0] pend_dec;

  assign count     = byte_i[CountBits-1:0];
  assign lines_dec = lines_q - 16'd1;
  assign pend_dec  = pend_q - CountBits'(1);

  // next state
  always_comb begin
    phase_d   = phase_q;
    hdr_pos_d = hdr_pos_q;
    width_d   = width_q;
    lines_d   = lines_q;
    pend_d    = pend_q;
    skip_d    = skip_q;
    case (phase_q)
      PH_HEADER: begin
        case (hdr_pos_q)
          HdrWidthLo:  width_d = {width_q[15:8], byte_i};
          HdrWidthHi:  width_d = {byte_i, width_q[7:0]};
          HdrHeightLo: lines_d = {lines_q[15:8], byte_i};
          HdrHeightHi: lines_d = {byte_i, lines_q[7:0]};
          default: ;
        endcase
        if (hdr_pos_q != HdrLast) begin
          hdr_pos_d = hdr_pos_q + 3'd1;
        end else begin
          hdr_pos_d = '0;
          skip_d    = 1'b0;
          phase_d   = (lines_q == '0) ? PH_DONE : PH_LENSKIP;
        end
      end
      PH_LENSKIP: begin
        skip_d = ~skip_q;
        if (skip_q) phase_d = PH_CONTROL;
      end
      PH_CONTROL: begin
        if (count == '0) begin
          lines_d = lines_dec;
          skip_d  = 1'b0;
          phase_d = (lines_dec == '0) ? PH_DONE : PH_LENSKIP;
        end else begin
          pend_d  = count;
          phase_d = byte_i[RepeatBit] ? PH_REPEAT : PH_LITERAL;
        end
      end
      PH_REPEAT: begin
        pend_d  = '0;
        phase_d = PH_CONTROL;
      end
      PH_LITERAL: begin
        pend_d = pend_dec;
        if (pend_dec == '0) phase_d = PH_CONTROL;
      end
      default: phase_d = PH_DONE;
    endcase
  end

  // result for the byte in hand
  always_comb begin
    res_o = '0;
    case (phase_q)
      PH_HEADER: begin
        if (hdr_pos_q == HdrLast) begin
          res_o.valid        = step_i;
          res_o.kind         = KIND_SIZE;
          res_o.image_width  = width_q;
          res_o.image_height = lines_q;
          res_o.image_done   = (lines_q == '0);
        end
      end
      PH_CONTROL: begin
        if (count == '0) begin
          res_o.valid      = step_i;
          res_o.kind       = KIND_EOL;
          res_o.image_done = (lines_dec == '0);
        end
      end
      PH_REPEAT: begin
        res_o.valid       = step_i;
        res_o.kind        = KIND_RUN;
        res_o.pixel_index = byte_i;
        res_o.run_length  = pend_q;
      end
      PH_LITERAL: begin
        res_o.valid       = step_i;
        res_o.kind        = KIND_RUN;
        res_o.pixel_index = byte_i;
        res_o.run_length  = CountBits'(1);
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q   <= PH_HEADER;
      hdr_pos_q <= '0;
      width_q   <= '0;
      lines_q   <= '0;
      pend_q    <= '0;
      skip_q    <= 1'b0;
    end else if (step_i) begin
      phase_q   <= phase_d;
      hdr_pos_q <= hdr_pos_d;
      width_q   <= width_d;
      lines_q   <= lines_d;
      pend_q    <= pend_d;
      skip_q    <= skip_d;
    end
  end

endmodule

`default_nettype wire

/* sv/cut_rle_image_decoder.sv */
// cut rle image decoder: file bytes in, size/run/line-end results out
// a byte waits in the input register; any result it yields is then registered
// throughput: one byte per cycle while the result register is free or draining;
// the parse step between the input and result registers is combinational
// reset: asynchronous, clears the parse state to the start of the header
// depends on crle_pkg, crle_byte_if, crle_result_if, crle_parser
`timescale 1ns / 1ps
`default_nettype none

module cut_rle_image_decoder (
  input  wire logic      clk_i,
  input  wire logic      rst_ni,
  crle_byte_if.sink      data_i,
  crle_result_if.source  result_o
);
  import crle_pkg::*;

  logic       in_valid_q, in_valid_d;
  logic [7:0] in_byte_q;
  logic       out_valid_q, out_valid_d;
  result_t    out_q;
  result_t    res;
  logic       adv;

  // input register moves on when the result register is free or draining
  assign adv          = in_valid_q && (!out_valid_q || result_o.ready);
  assign data_i.ready = !in_valid_q || adv;

  assign in_valid_d  = data_i.valid ? 1'b1 : (in_valid_q && !adv);
  assign out_valid_d = adv ? res.valid : (out_valid_q && !result_o.ready);

  crle_parser u_parser (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .step_i (adv),
    .byte_i (in_byte_q),
    .res_o  (res)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      if (data_i.ready) in_valid_q <= in_valid_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (data_i.valid && data_i.ready) in_byte_q <= data_i.data_byte;
    if (adv && res.valid) out_q <= res;
  end

  assign result_o.valid        = out_valid_q;
  assign result_o.kind         = out_q.kind;
  assign result_o.image_width  = out_q.image_width;
  assign result_o.image_height = out_q.image_height;
  assign result_o.pixel_index  = out_q.pixel_index;
  assign result_o.run_length   = out_q.run_length;
  assign result_o.image_done   = out_q.image_done;

endmodule

`default_nettype wire
